// File: hdl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants for the LRU key-value cache
// Field widths, command codes and the per-cell entry and control records.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    // capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // request opcodes
    typedef enum logic
    {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    // one cache entry as seen by its neighbor
    typedef struct packed
    {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } entry_t;

    // control broadcast to every cell
    typedef struct packed
    {
        logic step;   // a request is taken this cycle
        logic hit;    // the key is held somewhere in the chain
        logic put;    // request writes a value
        logic evict;  // store is at capacity, the oldest entry drops off
    } ctl_t;

endpackage : lkv_pkg

`default_nettype wire

// File: hdl/lkv_req_if.sv
// ----------------------------------------------------------------------------
// lkv_req_if: request channel of the LRU key-value cache
// Valid/ready handshake with a get/put command, key and write value.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkv_req_if;

    logic                valid;
    logic                ready;
    logic                command;
    logic signed [31:0]  lookup_key;
    logic signed [31:0]  write_value;

    modport source
    (
        output valid,
        output command,
        output lookup_key,
        output write_value,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  command,
        input  lookup_key,
        input  write_value,
        output ready
    );

endinterface : lkv_req_if

`default_nettype wire

// File: hdl/lkv_rsp_if.sv
// ----------------------------------------------------------------------------
// lkv_rsp_if: response channel of the LRU key-value cache
// Valid/ready handshake with the found flag and the read value.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkv_rsp_if;

    logic                valid;
    logic                ready;
    logic                found;
    logic signed [31:0]  read_value;

    modport source
    (
        output valid,
        output found,
        output read_value,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  found,
        input  read_value,
        output ready
    );

endinterface : lkv_rsp_if

`default_nettype wire

// File: hdl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store, LRU replacement
// Response: the found flag and read value are registered when the request is taken.
// Throughput: one request per cycle unless rsp.ready holds off; the cells
// update in the same edge, so the next request sees the previous result.
// Reset: the store is empty and cap_reg is 16; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write_en,
    input  wire logic [CAP_W-1:0] cfg_write_data,
    lkv_req_if.sink               req,
    lkv_rsp_if.source             rsp
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]        cap_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    rsp_valid_reg;
    logic                    found_reg;
    logic signed [VAL_W-1:0] read_value_reg;

    logic [CMP_W-1:0]        cap_wide;
    logic [CMP_W-1:0]        eff_cap;
    logic                    accept;
    logic                    is_put;
    ctl_t                    ctl;
    entry_t                  head_entry;

    entry_t                  ents       [MAX_ENTRIES];
    logic                    hit_chain  [MAX_ENTRIES+1];
    logic signed [VAL_W-1:0] val_chain  [MAX_ENTRIES+1];

    // handshake: the response register frees as it is taken
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_put    = (req.command == CMD_PUT);

    // capacity clamped to 1..MAX_ENTRIES
    assign cap_wide = CMP_W'(cap_reg);
    always_comb
    begin
        if (cap_wide == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_wide > CMP_W'(MAX_ENTRIES))
        begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = cap_wide;
        end
    end

    // broadcast control
    assign ctl.step  = accept;
    assign ctl.hit   = hit_chain[0];
    assign ctl.put   = is_put;
    assign ctl.evict = (CMP_W'(count_reg) >= eff_cap);

    // new most recent entry entering at the head
    assign head_entry.valid = 1'b1;
    assign head_entry.key   = req.lookup_key;
    assign head_entry.value = is_put ? req.write_value : val_chain[0];

    // chain tails
    assign hit_chain[MAX_ENTRIES] = 1'b0;
    assign val_chain[MAX_ENTRIES] = '0;

    // row of cells, index 0 most recent
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        entry_t prev;
        if (i == 0)
        begin : g_head
            assign prev = head_entry;
        end
        else
        begin : g_body
            assign prev = ents[i-1];
        end

        lkv_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .key        (req.lookup_key),
            .prev_entry (prev),
            .entry      (ents[i]),
            .hit_in     (hit_chain[i+1]),
            .hit_out    (hit_chain[i]),
            .value_in   (val_chain[i+1]),
            .value_out  (val_chain[i])
        );
    end

    // occupancy grows only on an insert that does not evict
    always_comb
    begin
        count_next = count_reg;
        if (accept && is_put && !ctl.hit && !ctl.evict)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // config, occupancy and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                cap_reg <= cfg_write_data;
            end
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg      <= hit_chain[0];
            read_value_reg <= (!is_put && hit_chain[0]) ? val_chain[0] : '0;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.found      = found_reg;
    assign rsp.read_value = read_value_reg;

endmodule : lru_key_value_cache

`default_nettype wire

// File: hdl/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell: one position of the recency-ordered entry chain
// Holds one entry; position in the chain is its recency rank. On an update
// the cell takes its more recent neighbor's entry when the shift reaches it.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_cell
    import lkv_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ctl_t                    ctl,
    input  wire logic signed [KEY_W-1:0] key,
    input  wire entry_t                  prev_entry,
    output entry_t                       entry,
    input  wire logic                    hit_in,
    output logic                         hit_out,
    input  wire logic signed [VAL_W-1:0] value_in,
    output logic signed [VAL_W-1:0]      value_out
);

    logic                    valid_reg;
    logic                    valid_next;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic                    match;
    logic                    shift;

    // key compare and the hit / value chains toward the head
    assign match     = valid_reg && (key_reg == key);
    assign hit_out   = hit_in | match;
    assign value_out = value_in | (match ? value_reg : '0);

    // shift reaches this cell: up to the hit, through the oldest entry on
    // an evicting insert, or into the first free cell otherwise
    always_comb
    begin
        if (ctl.hit)
        begin
            shift = ctl.step && hit_out;
        end
        else if (ctl.evict)
        begin
            shift = ctl.step && ctl.put && valid_reg;
        end
        else
        begin
            shift = ctl.step && ctl.put && prev_entry.valid;
        end
    end

    assign valid_next = shift ? prev_entry.valid : valid_reg;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg   <= prev_entry.key;
            value_reg <= prev_entry.value;
        end
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

endmodule : lkv_cell

`default_nettype wire

// File: dv/lkv_cache_checker.sv
// ----------------------------------------------------------------------------
// lkv_cache_checker: response scoreboard for the LRU key-value cache
// Watches the request, response and capacity ports and keeps its own copy of
// the store. It computes the expected found flag and read value of every
// accepted request and compares them, in order, with the responses taken.
// ----------------------------------------------------------------------------

module lkv_cache_checker
    import lkv_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [CAP_W-1:0] cfg_write_data,
    lkv_req_if               req,
    lkv_rsp_if               rsp,
    output int unsigned      mismatches,
    output int unsigned      outstanding,
    output int unsigned      responses_checked,
    output int unsigned      hits_seen
);

    localparam int RANK_W = $clog2(DEPTH);

    typedef struct packed
    {
        logic             found;
        logic [VAL_W-1:0] read_value;
    } lookup_result_t;

    // shadow copy of the store
    logic [KEY_W-1:0]  key_store   [DEPTH];
    logic [VAL_W-1:0]  value_store [DEPTH];
    logic              live        [DEPTH];
    logic [RANK_W-1:0] age         [DEPTH];
    logic [RANK_W:0]   occupancy;
    logic [CAP_W-1:0]  capacity;

    lookup_result_t expected_lookups [$];

    // slot becomes most recent; only entries newer than it age by one
    function automatic void make_recent(input int slot);
        logic [RANK_W-1:0] prior;
        prior = age[slot];
        for (int i = 0; i < DEPTH; i++)
        begin
            if (live[i] && i != slot && age[i] < prior)
                age[i] = age[i] + 1'b1;
        end
        age[slot] = '0;
    endfunction

    // one get or put against the shadow store
    function automatic lookup_result_t cache_access(input cmd_t cmd,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [VAL_W-1:0] data);
        lookup_result_t res;
        int hit;
        int slot;
        int oldest;
        int limit;
        hit = -1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hit < 0 && live[i] && key_store[i] == key)
                hit = i;
        end
        res.found      = (hit >= 0);
        res.read_value = '0;

        if (cmd == CMD_GET)
        begin
            if (hit >= 0)
            begin
                res.read_value = value_store[hit];
                make_recent(hit);
            end
        end
        else if (hit >= 0)
        begin
            value_store[hit] = data;
            make_recent(hit);
        end
        else
        begin
            // zero acts as one, oversize acts as full depth
            if (capacity == 0)
                limit = 1;
            else if (capacity > DEPTH)
                limit = DEPTH;
            else
                limit = capacity;

            // at or over capacity: drop the least recent entry first
            slot = -1;
            if (occupancy >= limit)
            begin
                oldest = -1;
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (live[i] && (oldest < 0 || age[i] > age[oldest]))
                        oldest = i;
                end
                if (oldest >= 0)
                begin
                    live[oldest] = 1'b0;
                    if (occupancy > 0)
                        occupancy = occupancy - 1'b1;
                end
                slot = oldest;
            end
            if (slot < 0)
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (slot < 0 && !live[i])
                        slot = i;
                end
            end
            if (slot < 0)
                slot = 0;

            // everyone else gets older, saturating at the oldest rank
            for (int i = 0; i < DEPTH; i++)
            begin
                if (live[i] && age[i] < DEPTH - 1)
                    age[i] = age[i] + 1'b1;
            end
            key_store[slot]   = key;
            value_store[slot] = data;
            live[slot]        = 1'b1;
            age[slot]         = '0;
            if (occupancy < DEPTH)
                occupancy = occupancy + 1'b1;
        end
        return res;
    endfunction

    // sample all ports at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                key_store[i]   = '0;
                value_store[i] = '0;
                live[i]        = 1'b0;
                age[i]         = '0;
            end
            occupancy = '0;
            capacity  = CAP_RESET;
            expected_lookups.delete();
            mismatches        = 0;
            responses_checked = 0;
            hits_seen         = 0;
        end
        else
        begin
            // response side first: it belongs to an earlier request
            if (rsp.valid && rsp.ready)
            begin
                if (expected_lookups.size() == 0)
                begin
                    $error("response with no request outstanding: found=%0b read_value=%h",
                           rsp.found, rsp.read_value);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    responses_checked = responses_checked + 1;
                    if (want.found)
                        hits_seen = hits_seen + 1;
                    if (rsp.found !== want.found)
                    begin
                        $error("found: expected %0b, actual %0b", want.found, rsp.found);
                        mismatches = mismatches + 1;
                    end
                    if (rsp.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %h, actual %h",
                               want.read_value, rsp.read_value);
                        mismatches = mismatches + 1;
                    end
                end
            end

            if (req.valid && req.ready)
                expected_lookups.push_back(cache_access(cmd_t'(req.command),
                                                        req.lookup_key,
                                                        req.write_value));

            if (cfg_write_en)
                capacity = cfg_write_data;
        end
        outstanding = expected_lookups.size();
    end

endmodule : lkv_cache_checker

// File: dv/tb_lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache: testbench top for the LRU key-value cache
// Directed gets and puts on edge keys and values, then random traffic over a
// small key set per phase so that hits, overwrites and evictions are common,
// across several capacity settings and idle/stall patterns on both channels.
// ----------------------------------------------------------------------------

module tb_lru_key_value_cache;

    import lkv_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int POOL_SIZE   = 20;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 100;

    logic             clk;
    logic             rst_n;
    logic             cfg_write_en;
    logic [CAP_W-1:0] cfg_write_data;

    lkv_req_if req_ch ();
    lkv_rsp_if rsp_ch ();

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned responses_checked;
    int unsigned hits_seen;

    int send_idle_pct;
    int recv_stall_pct;
    int requests_sent;
    int capacity_writes;
    int pool_span;
    int cycle_count;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    // capacity per random phase: extremes, out-of-range and in between
    logic [CAP_W-1:0] phase_cap [PHASES] = '{5'd31, 5'd17, 5'd1, 5'd4, 5'd16, 5'd8,
                                             5'd3, 5'd12, 5'd5, 5'd2, 5'd16, 5'd7};

    lru_key_value_cache #(
        .MAX_ENTRIES (DEPTH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .req            (req_ch),
        .rsp            (rsp_ch)
    );

    lkv_cache_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_write_data    (cfg_write_data),
        .req               (req_ch),
        .rsp               (rsp_ch),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .responses_checked (responses_checked),
        .hits_seen         (hits_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d responses still due",
                     cycle_count, outstanding);
            $display("Test completed with failures");
            $finish;
        end
    end

    // response side back-pressure
    always @(negedge clk)
        rsp_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);

    // drive one request, with random idle cycles ahead of it, until taken
    task automatic send_request(input cmd_t cmd, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] data);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid       = 1'b1;
        req_ch.command     = cmd;
        req_ch.lookup_key  = key;
        req_ch.write_value = data;
        do
            @(posedge clk);
        while (!req_ch.ready);
        requests_sent = requests_sent + 1;
    endtask

    // drop valid once the last request has been taken
    task automatic end_burst();
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    // capacity changes only with the cache drained
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        end_burst();
        while (outstanding != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_write_en   = 1'b1;
        cfg_write_data = cap;
        @(negedge clk);
        cfg_write_en    = 1'b0;
        capacity_writes = capacity_writes + 1;
    endtask

    // fresh key set, a few more keys than the cache holds
    task automatic refill_keys(input logic [CAP_W-1:0] cap);
        int held;
        held = (cap == 0) ? 1 : (cap > DEPTH) ? DEPTH : cap;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        key_pool[$urandom_range(0, POOL_SIZE - 1)] = 32'h8000_0000;
        key_pool[$urandom_range(0, POOL_SIZE - 1)] = 32'h7FFF_FFFF;
        pool_span = held + $urandom_range(1, 4);
        if (pool_span > POOL_SIZE)
            pool_span = POOL_SIZE;
    endtask

    task automatic run_random(input int count);
        cmd_t             cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] data;
        for (int n = 0; n < count; n++)
        begin
            cmd = ($urandom_range(0, 99) < 55) ? CMD_PUT : CMD_GET;
            // mostly reused keys, some fresh random ones that almost always miss
            if ($urandom_range(0, 99) < 88)
                key = key_pool[$urandom_range(0, pool_span - 1)];
            else
                key = $urandom;
            case ($urandom_range(0, 9))
                0:       data = 32'h8000_0000;
                1:       data = 32'h7FFF_FFFF;
                2:       data = '0;
                default: data = $urandom;
            endcase
            send_request(cmd, key, data);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n              = 1'b0;
        cfg_write_en       = 1'b0;
        cfg_write_data     = '0;
        req_ch.valid       = 1'b0;
        req_ch.command     = CMD_GET;
        req_ch.lookup_key  = '0;
        req_ch.write_value = '0;
        rsp_ch.ready       = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        requests_sent      = 0;
        capacity_writes    = 0;
        cycle_count        = 0;
        pool_span          = 1;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty store, edge keys and values, put over an existing key
        send_request(CMD_GET, 32'h0000_0000, 32'h0);
        send_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_GET, 32'h8000_0000, 32'h0);
        send_request(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_PUT, 32'h0000_0000, 32'h1234_5678);
        send_request(CMD_GET, 32'h0000_0000, 32'h0);
        send_request(CMD_GET, 32'h0000_0001, 32'h0);
        send_request(CMD_GET, 32'hFFFF_FFFF, 32'h0);

        // capacity dropped below occupancy, then LRU order with two entries
        set_capacity(5'd2);
        send_request(CMD_PUT, 32'd5, 32'd50);
        send_request(CMD_PUT, 32'd6, 32'd60);
        send_request(CMD_GET, 32'd5, 32'h0);
        send_request(CMD_PUT, 32'd7, 32'd70);
        send_request(CMD_GET, 32'd6, 32'h0);
        send_request(CMD_GET, 32'd5, 32'h0);
        send_request(CMD_GET, 32'd7, 32'h0);

        // capacity zero behaves as one
        set_capacity(5'd0);
        send_request(CMD_PUT, 32'd8, 32'd80);
        send_request(CMD_GET, 32'd8, 32'h0);
        send_request(CMD_PUT, 32'd9, 32'd90);
        send_request(CMD_GET, 32'd8, 32'h0);
        send_request(CMD_GET, 32'd9, 32'h0);

        // random phases, rotating through the idle/stall patterns
        for (int p = 0; p < PHASES; p++)
        begin
            set_capacity(phase_cap[p]);
            refill_keys(phase_cap[p]);
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            run_random(PHASE_ITEMS);
        end

        // drain, then allow the response latency to settle
        end_burst();
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        $display("Covered %0d requests over %0d capacity settings; %0d responses checked, %0d hits",
                 requests_sent, capacity_writes, responses_checked, hits_seen);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule : tb_lru_key_value_cache
